@@ rtl/nlp_pkg.sv @@
// shared constants and types for the next lexicographic permutation block
// no dependencies; used by rtl/next_lexicographic_permutation.sv
package nlp_pkg;

   localparam int MAX_SYMBOLS   = 8;
   localparam int SYMBOL_BITS   = 8;
   localparam int WORD_BITS     = 64;
   localparam int CFG_BITS      = 4;
   localparam int SYM_WORD_BITS = MAX_SYMBOLS * SYMBOL_BITS;
   localparam int IDX_BITS      = $clog2(MAX_SYMBOLS);
   localparam int LEN_BITS      = $clog2(MAX_SYMBOLS + 1);
   localparam int SUM_BITS      = LEN_BITS + 1;

   localparam logic [CFG_BITS-1:0] ACTIVE_LENGTH_RESET = 4'd8;

   typedef logic [SYMBOL_BITS-1:0]                  symbol_type;
   typedef logic [MAX_SYMBOLS-1:0][SYMBOL_BITS-1:0] sym_vec_type;
   typedef logic [IDX_BITS-1:0]                     idx_type;
   typedef logic [LEN_BITS-1:0]                     len_type;

endpackage

@@ rtl/next_lexicographic_permutation.sv @@
// top level: four-stage pipeline computing the lexicographic successor of a word
// depends on rtl/nlp_pkg.sv
//
// Takes one word of up to MAX_SYMBOLS unsigned byte symbols per cycle and returns
// its lexicographic successor among arrangements of the same symbols. A word with
// no rise (non-increasing) wraps to the ascending order with rsp_wrapped high.
// Symbols at or beyond the active length are ignored on input and zero on output;
// csr_write_data of 0 acts as 1, values above MAX_SYMBOLS act as MAX_SYMBOLS.
// rsp_valid rises once the word has moved through the stage 1, 2 and 3 registers
// into stage 4; throughput one word per cycle unless stalled. Stages: length
// clamp and masking, last-rise search, successor-symbol search, swap plus tail
// reversal into the output register. Each stage has its own valid bit and advances
// when its successor is empty or advancing, so bubbles collapse and req_ready
// falls only when all four stages hold words and the output is stalled. Change
// csr only while the pipeline is empty.
module next_lexicographic_permutation (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [nlp_pkg::WORD_BITS-1:0]       req_current_perm,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [nlp_pkg::WORD_BITS-1:0]       rsp_next_perm,
   output logic                                rsp_wrapped,
   input  logic                                csr_write_enable,
   input  logic [nlp_pkg::CFG_BITS-1:0]        csr_write_data
);

   // configuration register
   logic [nlp_pkg::CFG_BITS-1:0] csr_active_length_ff;
   nlp_pkg::len_type             eff_len;

   // per-stage valid bits and advance enables
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;

   // stage 1: masked symbols and clamped length
   nlp_pkg::sym_vec_type s1_sym_ff, s1_sym_in;
   nlp_pkg::len_type     s1_len_ff;

   // stage 2: last rise
   nlp_pkg::sym_vec_type s2_sym_ff;
   nlp_pkg::len_type     s2_len_ff;
   nlp_pkg::idx_type     s2_k_ff, s2_k_in;
   logic                 s2_rise_ff, s2_rise_in;

   // stage 3: rightmost symbol after k that exceeds symbol k
   nlp_pkg::sym_vec_type s3_sym_ff;
   nlp_pkg::len_type     s3_len_ff;
   nlp_pkg::idx_type     s3_k_ff, s3_j_ff, s3_j_in;
   logic                 s3_rise_ff;
   nlp_pkg::symbol_type  s3_sk_ff, s3_sj_ff, s3_sk_in;

   // stage 4: output register
   nlp_pkg::sym_vec_type s4_sym_ff, s4_sym_in;
   logic                 s4_wrap_ff;

   // elastic pipeline control: a stage moves when the next one can take it
   assign adv4      = !v4_ff || rsp_ready;
   assign adv3      = !v3_ff || adv4;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;
   assign rsp_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_active_length_ff <= nlp_pkg::ACTIVE_LENGTH_RESET;
      end else if (csr_write_enable) begin
         csr_active_length_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= req_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
         if (adv4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // ---------------- stage 1: clamp length, zero unused symbols ----------------
   always_comb begin
      if (csr_active_length_ff == '0) begin
         eff_len = nlp_pkg::len_type'(1);
      end else if (int'(csr_active_length_ff) > nlp_pkg::MAX_SYMBOLS) begin
         eff_len = nlp_pkg::len_type'(nlp_pkg::MAX_SYMBOLS);
      end else begin
         eff_len = nlp_pkg::len_type'(csr_active_length_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < nlp_pkg::MAX_SYMBOLS; i++) begin
         if (nlp_pkg::len_type'(i) < eff_len) begin
            s1_sym_in[i] = req_current_perm[i*nlp_pkg::SYMBOL_BITS +: nlp_pkg::SYMBOL_BITS];
         end else begin
            s1_sym_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_sym_ff <= s1_sym_in;
         s1_len_ff <= eff_len;
      end
   end

   // ---------------- stage 2: last position k with sym[k] < sym[k+1] ----------
   always_comb begin
      s2_k_in    = '0;
      s2_rise_in = 1'b0;
      for (int i = 0; i < nlp_pkg::MAX_SYMBOLS - 1; i++) begin
         if ((nlp_pkg::len_type'(i + 1) < s1_len_ff) && (s1_sym_ff[i] < s1_sym_ff[i+1])) begin
            s2_k_in    = nlp_pkg::idx_type'(i);
            s2_rise_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_sym_ff  <= s1_sym_ff;
         s2_len_ff  <= s1_len_ff;
         s2_k_ff    <= s2_k_in;
         s2_rise_ff <= s2_rise_in;
      end
   end

   // ---------------- stage 3: rightmost j > k with sym[j] > sym[k] -------------
   // tail after k is non-increasing, so this is the smallest symbol above sym[k]
   assign s3_sk_in = s2_sym_ff[s2_k_ff];

   always_comb begin
      s3_j_in = s2_k_ff;
      for (int i = 0; i < nlp_pkg::MAX_SYMBOLS; i++) begin
         if ((nlp_pkg::idx_type'(i) > s2_k_ff) && (nlp_pkg::len_type'(i) < s2_len_ff) &&
             (s2_sym_ff[i] > s3_sk_in)) begin
            s3_j_in = nlp_pkg::idx_type'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_sym_ff  <= s2_sym_ff;
         s3_len_ff  <= s2_len_ff;
         s3_k_ff    <= s2_k_ff;
         s3_j_ff    <= s3_j_in;
         s3_rise_ff <= s2_rise_ff;
         s3_sk_ff   <= s3_sk_in;
         s3_sj_ff   <= s2_sym_ff[s3_j_in];
      end
   end

   // ---------------- stage 4: swap k and j, reverse from lo up to n-1 ----------
   // with no rise the whole active word reverses (ascending restart)
   always_comb begin
      nlp_pkg::sym_vec_type             swapped;
      logic [nlp_pkg::SUM_BITS-1:0]     lo;
      logic [nlp_pkg::SUM_BITS-1:0]     src;
      swapped = s3_sym_ff;
      if (s3_rise_ff) begin
         swapped[s3_j_ff] = s3_sk_ff;
         swapped[s3_k_ff] = s3_sj_ff;
         lo = nlp_pkg::SUM_BITS'(s3_k_ff) + nlp_pkg::SUM_BITS'(1);
      end else begin
         lo = '0;
      end
      for (int i = 0; i < nlp_pkg::MAX_SYMBOLS; i++) begin
         src = lo + nlp_pkg::SUM_BITS'(s3_len_ff) - nlp_pkg::SUM_BITS'(1)
               - nlp_pkg::SUM_BITS'(i);
         if (nlp_pkg::SUM_BITS'(i) < lo) begin
            s4_sym_in[i] = swapped[i];
         end else if (nlp_pkg::len_type'(i) < s3_len_ff) begin
            s4_sym_in[i] = swapped[src[nlp_pkg::IDX_BITS-1:0]];
         end else begin
            s4_sym_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_sym_ff  <= s4_sym_in;
         s4_wrap_ff <= !s3_rise_ff;
      end
   end

   assign rsp_next_perm = nlp_pkg::WORD_BITS'(s4_sym_ff);
   assign rsp_wrapped   = s4_wrap_ff;

   // ---------------- assertions ----------------
   // clamped length in the pipe is always within 1..MAX_SYMBOLS
   a_len_range : assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (s2_len_ff != '0) && (int'(s2_len_ff) <= nlp_pkg::MAX_SYMBOLS))
      else $error("stage 2 length out of range");

   // a rise always has a successor symbol strictly to its right
   a_j_after_k : assert property (@(posedge clock) disable iff (reset)
      v3_ff && s3_rise_ff |-> (s3_j_ff > s3_k_ff) && (s3_j_ff < s3_len_ff))
      else $error("successor position not after the rise");

   // the symbol swapped in at k is strictly larger than the one it replaces
   a_j_larger : assert property (@(posedge clock) disable iff (reset)
      v3_ff && s3_rise_ff |-> s3_sj_ff > s3_sk_ff)
      else $error("successor symbol not larger than rise symbol");

endmodule

@@ bench/tb_next_lexicographic_permutation.sv @@
`timescale 1ns / 100ps
// self-checking bench for next_lexicographic_permutation: directed and random words
// over many active lengths, checked against a successor predictor kept in the bench
// depends on rtl/nlp_pkg.sv and rtl/next_lexicographic_permutation.sv

module tb_next_lexicographic_permutation;

   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no reset, handshake or csr write
   localparam int LONG_HOLD      = 60;     // receiver back-pressure stretch
   localparam int DRAIN_CYCLES   = 8;      // pipeline is four deep, allow slack
   localparam int PHASE_WORDS    = 110;
   localparam int NUM_PHASES     = 12;
   localparam int NUM_DIRECTED   = 16;
   localparam int REPORT_LIMIT   = 10;

   typedef logic [nlp_pkg::WORD_BITS-1:0] word_type;
   typedef logic [nlp_pkg::CFG_BITS-1:0]  length_cfg_type;
   typedef struct packed {
      word_type next_perm;
      logic     wrapped;
   } successor_type;

   // symbol 0 sits in the low byte
   localparam word_type DIRECTED_WORDS [NUM_DIRECTED] = '{
      64'h0000_0000_0000_0000,   // all symbols equal, zero
      64'hFFFF_FFFF_FFFF_FFFF,   // all symbols equal, max
      64'h0707_0707_5555_5555,   // only equal runs descending... wrap
      64'h0706_0504_0302_0100,   // ascending, rise at the very end
      64'h0001_0203_0405_0607,   // strictly descending, wraps to ascending
      64'h0000_0000_0000_FF00,   // max symbol next to zeros
      64'h0000_0000_0000_00FF,   // max first then zeros, descending
      64'h0404_0303_0202_0101,   // repeated symbols ascending
      64'h0000_0101_0202_0303,   // last arrangement of a multiset
      64'h0002_0304_0506_0701,   // only rise at position zero
      64'h7F80_7F80_7F80_7F80,   // unsigned compare across 0x7f/0x80
      64'h0100_0000_0000_0000,   // single rise before the last symbol
      64'hFEFF_FFFF_FFFF_FFFF,   // near-equal descending
      64'hFFFF_FFFF_FFFF_FFFE,   // near-equal with rise at the start
      64'h0102_0102_0102_0102,   // alternating repeats
      64'h8000_0000_0000_0001    // extremes at both ends
   };

   // reset-value length last, extremes of the register included
   localparam length_cfg_type PHASE_LENGTHS [NUM_PHASES] = '{
      4'd1, 4'd2, 4'd3, 4'd0, 4'd4, 4'd15, 4'd5, 4'd6, 4'd7, 4'd9, 4'd2, 4'd8
   };

   // expected successors in acceptance order, plus the mirrored length register
   class perm_scoreboard;
      length_cfg_type length_reg;
      successor_type  awaited[$];
      int             words_seen;
      int             results_seen;
      int             wraps_seen;
      int             mismatches;
      int             strays;

      function new();
         length_reg   = nlp_pkg::ACTIVE_LENGTH_RESET;
         words_seen   = 0;
         results_seen = 0;
         wraps_seen   = 0;
         mismatches   = 0;
         strays       = 0;
      endfunction

      // clamp of the register: zero acts as one, above the maximum acts as the maximum
      function int active_symbols();
         if (length_reg == 0)
            return 1;
         if (length_reg > nlp_pkg::MAX_SYMBOLS)
            return nlp_pkg::MAX_SYMBOLS;
         return int'(length_reg);
      endfunction

      function successor_type successor_of(word_type w);
         nlp_pkg::symbol_type sym [nlp_pkg::MAX_SYMBOLS];
         nlp_pkg::symbol_type t;
         successor_type       r;
         int                  n;
         int                  k;
         int                  j;
         int                  lo;
         int                  hi;
         bit                  rise;
         n = active_symbols();
         for (int i = 0; i < nlp_pkg::MAX_SYMBOLS; i++)
            sym[i] = (i < n) ? w[i*nlp_pkg::SYMBOL_BITS +: nlp_pkg::SYMBOL_BITS] : '0;
         // last position whose symbol is below its right neighbor
         rise = 1'b0;
         k    = 0;
         for (int i = 0; i + 1 < n; i++) begin
            if (sym[i] < sym[i+1]) begin
               k    = i;
               rise = 1'b1;
            end
         end
         lo = 0;
         if (rise) begin
            // tail is non-increasing: rightmost symbol above sym[k] is the smallest one
            j = n - 1;
            while (j > k && sym[j] <= sym[k])
               j--;
            t      = sym[j];
            sym[j] = sym[k];
            sym[k] = t;
            lo     = k + 1;
         end
         // reverse the tail, or the whole word on wrap
         hi = n - 1;
         while (lo < hi) begin
            t       = sym[lo];
            sym[lo] = sym[hi];
            sym[hi] = t;
            lo++;
            hi--;
         end
         r.next_perm = '0;
         for (int i = 0; i < n; i++)
            r.next_perm[i*nlp_pkg::SYMBOL_BITS +: nlp_pkg::SYMBOL_BITS] = sym[i];
         r.wrapped = !rise;
         return r;
      endfunction

      function void note_word(word_type w);
         words_seen++;
         awaited = {awaited, successor_of(w)};
      endfunction

      function void check_result(word_type got_perm, logic got_wrapped);
         successor_type want;
         results_seen++;
         if (awaited.size() == 0) begin
            strays++;
            if (mismatches + strays <= REPORT_LIMIT)
               $display("unexpected result: next_perm %h wrapped %b", got_perm, got_wrapped);
            return;
         end
         want = awaited.pop_front();
         if (got_wrapped === 1'b1)
            wraps_seen++;
         if (got_perm !== want.next_perm || got_wrapped !== want.wrapped) begin
            mismatches++;
            if (mismatches + strays <= REPORT_LIMIT)
               $display("mismatch at result %0d (len %0d): exp %h/%b got %h/%b",
                        results_seen, length_reg, want.next_perm, want.wrapped,
                        got_perm, got_wrapped);
         end
      endfunction

      function int pending_count();
         return awaited.size();
      endfunction
   endclass

   logic           clock            = 1'b0;
   logic           reset            = 1'b1;
   logic           req_valid        = 1'b0;
   logic           req_ready;
   word_type       req_current_perm = '0;
   logic           rsp_valid;
   logic           rsp_ready        = 1'b0;
   word_type       rsp_next_perm;
   logic           rsp_wrapped;
   logic           csr_write_enable = 1'b0;
   length_cfg_type csr_write_data   = '0;

   // idling knobs for the sender and the receiver, in percent
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   // long back-pressure requests from the stimulus, served by the receiver
   int holds_requested = 0;
   int holds_done      = 0;

   perm_scoreboard sb;

   next_lexicographic_permutation u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_current_perm (req_current_perm),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_perm    (rsp_next_perm),
      .rsp_wrapped      (rsp_wrapped),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // handshakes are seen with pre-edge values, since all drives are nonblocking
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_word(req_current_perm);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_next_perm, rsp_wrapped);
      end
   end

   // receiver: random stalls, plus a long hold whenever the stimulus asks for one
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (holds_done != holds_requested) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog: ends the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL");
      $finish;
   end

   // offer one word; valid is left high so a back-to-back word needs no re-raise
   task automatic send_word(word_type w);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_current_perm <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait for every outstanding word to come back
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_count() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      word_type      cursor;
      word_type      unused_mask;
      successor_type step;
      int            n;
      int            v;

      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the reset length of eight, no idling
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_word(DIRECTED_WORDS[i]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         // length changes only with the pipeline empty
         drain_pipeline();
         csr_write_enable <= 1'b1;
         csr_write_data   <= PHASE_LENGTHS[p];
         @(posedge clock);
         csr_write_enable <= 1'b0;
         sb.length_reg = PHASE_LENGTHS[p];

         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 50;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 50;
            end
            default: begin
               send_idle_pct = 13;
               stall_pct     = 13;
            end
         endcase

         n = sb.active_symbols();
         unused_mask = '0;
         for (int b = n; b < nlp_pkg::MAX_SYMBOLS; b++)
            unused_mask[b*nlp_pkg::SYMBOL_BITS +: nlp_pkg::SYMBOL_BITS] = '1;

         cursor = '0;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            // halfway through, let the block run dry before carrying on
            if (i == PHASE_WORDS / 2)
               drain_pipeline();
            // in no-idle phases, stall the output long enough to back up the input
            if (i == 20 && (p % 4) == 0)
               holds_requested++;

            if (i == 0 || $urandom_range(99) < 15) begin
               // fresh seed of one of several shapes
               case ($urandom_range(3))
                  0: cursor = {$urandom, $urandom};
                  1: begin
                     // tiny alphabet, lots of repeated symbols
                     for (int b = 0; b < nlp_pkg::MAX_SYMBOLS; b++)
                        cursor[b*nlp_pkg::SYMBOL_BITS +: nlp_pkg::SYMBOL_BITS] =
                           nlp_pkg::symbol_type'($urandom_range(3));
                  end
                  2: begin
                     // non-increasing word, so it wraps
                     v = $urandom_range(255);
                     for (int b = 0; b < nlp_pkg::MAX_SYMBOLS; b++) begin
                        cursor[b*nlp_pkg::SYMBOL_BITS +: nlp_pkg::SYMBOL_BITS] =
                           nlp_pkg::symbol_type'(v);
                        v = v - $urandom_range(0, (v < 40) ? v : 40);
                     end
                  end
                  default: begin
                     // one symbol repeated everywhere
                     v = $urandom_range(255);
                     for (int b = 0; b < nlp_pkg::MAX_SYMBOLS; b++)
                        cursor[b*nlp_pkg::SYMBOL_BITS +: nlp_pkg::SYMBOL_BITS] =
                           nlp_pkg::symbol_type'(v);
                  end
               endcase
            end else begin
               // walk the enumeration: next input is the predicted successor
               step   = sb.successor_of(cursor);
               cursor = step.next_perm;
            end
            // junk in the ignored positions half the time
            if ($urandom_range(1) == 1)
               cursor = cursor | ({$urandom, $urandom} & unused_mask);
            send_word(cursor);
         end
      end

      drain_pipeline();
      $display("run covered %0d words and %0d results, %0d of them wrapped",
               sb.words_seen, sb.results_seen, sb.wraps_seen);
      $display("over %0d length settings incl. 0 and 15, %0d long output holds, %0d mismatches",
               NUM_PHASES + 1, holds_done, sb.mismatches + sb.strays);
      if (sb.mismatches == 0 && sb.strays == 0 && sb.pending_count() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/nlp_pkg.sv
rtl/next_lexicographic_permutation.sv
bench/tb_next_lexicographic_permutation.sv
